>>> rtl/pidvr_pkg.sv
// ----------------------------------------------------------------------------
// pidvr_pkg
// Shared types and constants of the PID voltage regulator: field widths,
// register indexes, reset values and the setpoint limit.
// ----------------------------------------------------------------------------
package pidvr_pkg;

    // Field widths fixed by the data formats
    localparam int VOLT_W      = 15;   // unsigned volts, 8 fraction bits
    localparam int GAIN_W      = 16;   // signed gain, 8 fraction bits
    localparam int ERR_W       = 16;   // signed error and derivative
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Products carry 16 fraction bits, which are dropped from the drive.
    localparam int DRIVE_SHIFT = 16;

    // Highest setpoint accepted: 75 V with 8 fraction bits.
    localparam logic [VOLT_W-1:0] TARGET_LIMIT = VOLT_W'(75 << 8);

    // Register reset values
    localparam logic [VOLT_W-1:0] TARGET_RESET = '0;
    localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = 16'sd2560;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RESET = 16'sd205;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RESET = 16'sd0;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_VOLTAGE    = 2'd0,
        CFG_GAIN_PROPORTIONAL = 2'd1,
        CFG_GAIN_INTEGRAL     = 2'd2,
        CFG_GAIN_DERIVATIVE   = 2'd3
    } cfg_reg_t;

endpackage

>>> rtl/pidvr_meas_if.sv
// ----------------------------------------------------------------------------
// pidvr_meas_if
// Valid/ready channel carrying one measured supply voltage per item.
// ----------------------------------------------------------------------------
interface pidvr_meas_if;
    import pidvr_pkg::*;

    logic              valid;
    logic              ready;
    logic [VOLT_W-1:0] measured_voltage;

    modport source (output valid, output measured_voltage, input ready);
    modport sink   (input valid, input measured_voltage, output ready);

endinterface

>>> rtl/pidvr_dac_if.sv
// ----------------------------------------------------------------------------
// pidvr_dac_if
// Valid/ready channel carrying one DAC code per item.
// ----------------------------------------------------------------------------
interface pidvr_dac_if #(
    parameter int DAC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [DAC_BITS-1:0] dac_code;

    modport source (output valid, output dac_code, input ready);
    modport sink   (input valid, input dac_code, output ready);

endinterface

>>> rtl/pid_voltage_regulator.sv
// ----------------------------------------------------------------------------
// pid_voltage_regulator
// Fixed-point PID regulator turning measured supply voltages into clamped
// DAC codes, with a saturating integral and derivative on the measurement.
// ----------------------------------------------------------------------------
// Usage
// The measurement channel takes one measured voltage per item and the result
// channel returns exactly one DAC code per item, in the same order. Both use
// valid/ready; an item moves on an edge where valid and ready are both high.
// The setpoint and the three gains are written through cfg_we, cfg_index and
// cfg_wdata, by the user only while the block is idle; the block itself
// does not enforce this. A setpoint above 75 V is ignored. Throughput: one
// item per cycle while the receiver keeps ready high. The block is a
// four-register pipeline (input, error/integral, products, result) and each
// register moves on as soon as the one after it is empty or being emptied,
// so the input keeps being accepted while a finished result waits for the
// receiver. When the receiver stalls, the pipeline fills up and ready on the
// measurement channel falls once all four registers hold items.
// Reset clears all valid flags, the integral and the previous measurement,
// and loads the reset values of the setpoint and gains. The derivative of
// the first item after reset is taken against a measurement of zero.
// ----------------------------------------------------------------------------
module pid_voltage_regulator #(
    parameter int DAC_BITS = 12,
    parameter int SUM_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pidvr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pidvr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    pidvr_meas_if.sink                           measurement,
    pidvr_dac_if.source                          result
);
    import pidvr_pkg::*;

    // The drive is the sum of three signed products; the integral term is the
    // widest, and two guard bits cover the sum of three terms.
    localparam int IPROD_W = SUM_BITS + GAIN_W;
    localparam int PROD_W  = GAIN_W + ERR_W;
    localparam int DRV_W   = IPROD_W + 2;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
    localparam logic [DAC_BITS-1:0]        CODE_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [VOLT_W-1:0] target_reg;
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            gain_p_reg <= GAIN_P_RESET;
            gain_i_reg <= GAIN_I_RESET;
            gain_d_reg <= GAIN_D_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_TARGET_VOLTAGE:
                begin
                    // Setpoints above the 75 V limit leave the old value.
                    if (cfg_wdata[VOLT_W-1:0] <= TARGET_LIMIT)
                    begin
                        target_reg <= cfg_wdata[VOLT_W-1:0];
                    end
                end
                CFG_GAIN_PROPORTIONAL: gain_p_reg <= $signed(cfg_wdata[GAIN_W-1:0]);
                CFG_GAIN_INTEGRAL:     gain_i_reg <= $signed(cfg_wdata[GAIN_W-1:0]);
                CFG_GAIN_DERIVATIVE:   gain_d_reg <= $signed(cfg_wdata[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage may load when it is empty or
    // when the stage after it is moving on in the same cycle.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic st1_valid_reg;
    logic st2_valid_reg;
    logic out_valid_reg;

    logic out_adv;
    logic st2_adv;
    logic st1_adv;
    logic in_adv;

    assign out_adv = !out_valid_reg || result.ready;
    assign st2_adv = !st2_valid_reg || out_adv;
    assign st1_adv = !st1_valid_reg || st2_adv;
    assign in_adv  = !in_valid_reg  || st1_adv;

    assign measurement.ready = in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_valid_reg <= measurement.valid;
            end
            if (st1_adv)
            begin
                st1_valid_reg <= in_valid_reg;
            end
            if (st2_adv)
            begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= st2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic [VOLT_W-1:0] meas_reg;

    always_ff @(posedge clk)
    begin
        if (in_adv && measurement.valid)
        begin
            meas_reg <= measurement.measured_voltage;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: error, derivative on the measurement and saturating
    // integral. The integral and previous measurement are the loop state
    // and are updated as each item passes this stage.
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]    err_next;
    logic signed [ERR_W-1:0]    deriv_next;
    logic signed [SUM_BITS:0]   acc_wide;
    logic signed [SUM_BITS-1:0] sum_next;

    logic signed [SUM_BITS-1:0] sum_reg;
    logic        [VOLT_W-1:0]   prev_meas_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    deriv_reg;

    always_comb
    begin
        err_next   = $signed({1'b0, target_reg}) - $signed({1'b0, meas_reg});
        deriv_next = $signed({1'b0, meas_reg}) - $signed({1'b0, prev_meas_reg});
        acc_wide   = $signed({sum_reg[SUM_BITS-1], sum_reg})
                   + $signed({{(SUM_BITS+1-ERR_W){err_next[ERR_W-1]}}, err_next});
        // The two top bits differ only when the add has left the range.
        if (acc_wide[SUM_BITS] != acc_wide[SUM_BITS-1])
        begin
            sum_next = acc_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = acc_wide[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            prev_meas_reg <= '0;
        end
        else if (st1_adv && in_valid_reg)
        begin
            sum_reg       <= sum_next;
            prev_meas_reg <= meas_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st1_adv && in_valid_reg)
        begin
            err_reg   <= err_next;
            deriv_reg <= deriv_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three gain products, each registered on its own.
    // sum_reg already holds this item's integral when it is here.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]  p_prod_reg;
    logic signed [IPROD_W-1:0] i_prod_reg;
    logic signed [PROD_W-1:0]  d_prod_reg;

    always_ff @(posedge clk)
    begin
        if (st2_adv && st1_valid_reg)
        begin
            p_prod_reg <= gain_p_reg * err_reg;
            i_prod_reg <= gain_i_reg * sum_reg;
            d_prod_reg <= gain_d_reg * deriv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of the products, fraction bits dropped, and clamp to
    // the DAC range. A negative drive gives code zero.
    // ------------------------------------------------------------------
    logic signed [DRV_W-1:0]   drive;
    logic        [DAC_BITS-1:0] code_next;
    logic        [DAC_BITS-1:0] code_reg;

    always_comb
    begin
        drive = $signed({{(DRV_W-PROD_W){p_prod_reg[PROD_W-1]}}, p_prod_reg})
              + $signed({{(DRV_W-IPROD_W){i_prod_reg[IPROD_W-1]}}, i_prod_reg})
              + $signed({{(DRV_W-PROD_W){d_prod_reg[PROD_W-1]}}, d_prod_reg});
        if (drive[DRV_W-1])
        begin
            code_next = '0;
        end
        else if (|drive[DRV_W-2:DRIVE_SHIFT+DAC_BITS])
        begin
            code_next = CODE_MAX;
        end
        else
        begin
            code_next = drive[DRIVE_SHIFT +: DAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && st2_valid_reg)
        begin
            code_reg <= code_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.dac_code = code_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An item in the input register always reaches stage 1 when it moves.
    a_in_to_st1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && st1_adv) |=> st1_valid_reg)
        else $error("item lost between input register and stage 1");

    // The previous measurement follows the item that has just passed.
    a_prev_meas: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && st1_adv) |=> (prev_meas_reg == $past(meas_reg)))
        else $error("previous measurement not updated");

    // A negative drive must give code zero.
    a_neg_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (st2_valid_reg && out_adv && drive[DRV_W-1]) |=> (code_reg == '0))
        else $error("negative drive not clamped to zero");

    // With the result register empty the whole pipeline moves, so the
    // measurement channel must be ready.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> measurement.ready)
        else $error("input stalled while result register empty");

endmodule
